// ===== rtl/core/uv_sphere_grid_point_defines.svh =====
// ----------------------------------------------------------------------------
// UV sphere grid point assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_GRID_POINT_DEFINES_SVH
`define UV_SPHERE_GRID_POINT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge out of reset.
`define USG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next.
`define USG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define USG_ASSERT(lbl, prop, msg)
`define USG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/usg_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere grid point package
// Widths, register codes, CORDIC constants and the sideband record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package usg_pkg;

	localparam int DEF_MAX_GRID  = 1024;
	localparam int DEF_TRIG_BITS = 16;

	localparam int IDX_W      = 10;
	localparam int GRID_W     = 11;
	localparam int POS_W      = 17;
	localparam int TEX_W      = 17;
	localparam int CORNER_W   = 20;
	localparam int RA_W       = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_DW     = 13;
	localparam int TEX_SHIFT  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RADIUS_RST  = 16'd256;
	localparam logic [GRID_W-1:0]     RING_RST    = 11'd16;
	localparam logic [GRID_W-1:0]     SEGMENT_RST = 11'd16;

	localparam logic signed [32:0] CORDIC_K  = 33'sd652032874;
	localparam int                 POS_LIMIT = 65535;
	localparam logic [TEX_W-1:0]   TEX_ONE   = 17'd65536;

	typedef struct packed {
		logic              in_range;
		logic              faces;
		logic [RA_W-1:0]   ra;
		logic [GRID_W-1:0] rm1;
		logic [GRID_W-1:0] sm1;
		logic [TEX_W-1:0]  tex_s;
		logic [TEX_W-1:0]  tex_t;
	} side_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0:       v = 32'd536870912;
			1:       v = 32'd316933406;
			2:       v = 32'd167458907;
			3:       v = 32'd85004756;
			4:       v = 32'd42667331;
			5:       v = 32'd21354465;
			6:       v = 32'd10679838;
			7:       v = 32'd5340245;
			8:       v = 32'd2670163;
			9:       v = 32'd1335087;
			10:      v = 32'd667544;
			11:      v = 32'd333772;
			12:      v = 32'd166886;
			13:      v = 32'd83443;
			14:      v = 32'd41722;
			15:      v = 32'd20861;
			16:      v = 32'd10430;
			17:      v = 32'd5215;
			18:      v = 32'd2608;
			19:      v = 32'd1304;
			20:      v = 32'd652;
			21:      v = 32'd326;
			22:      v = 32'd163;
			23:      v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/usg_if.sv =====
// ----------------------------------------------------------------------------
// UV sphere grid point channels
// Configuration write, grid point input and vertex output interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface usg_cfg_if;
	import usg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface usg_in_if;
	import usg_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	modport source (output valid, row_index, col_index, input ready);
	modport sink (input valid, row_index, col_index, output ready);
endinterface

interface usg_out_if;
	import usg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic signed [POS_W-1:0]    pos_z;
	logic [TEX_W-1:0]           tex_s;
	logic [TEX_W-1:0]           tex_t;
	logic                       has_faces;
	logic                       in_range;
	logic [CORNER_W-1:0]        corner_a;
	logic [CORNER_W-1:0]        corner_b;
	logic [CORNER_W-1:0]        corner_c;
	logic [CORNER_W-1:0]        corner_d;
	modport source (output valid, pos_x, pos_y, pos_z, tex_s, tex_t, has_faces, in_range,
		corner_a, corner_b, corner_c, corner_d, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_s, tex_t, has_faces, in_range,
		corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

// ===== rtl/core/usg_cordic.sv =====
// ----------------------------------------------------------------------------
// UV sphere grid point CORDIC
// Pipelined rotation-mode sine and cosine, one iteration per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module usg_cordic #(
	parameter int TRIG_BITS = usg_pkg::DEF_TRIG_BITS
) (
	input  logic                   clk,
	input  logic [TRIG_BITS+1:0]   adv,
	input  logic [TRIG_BITS-1:0]   phase,
	output logic signed [TRIG_BITS:0] cos_val,
	output logic signed [TRIG_BITS:0] sin_val
);
	import usg_pkg::*;

	localparam int XW = 33;
	localparam int ZW = 32;
	localparam int RS = 32 - TRIG_BITS;
	localparam logic signed [XW-1:0] RND = XW'(1) <<< (RS - 1);

	logic signed [XW-1:0] x_s [0:TRIG_BITS];
	logic signed [XW-1:0] y_s [0:TRIG_BITS];
	logic signed [ZW-1:0] z_s [0:TRIG_BITS];
	logic [1:0]           quad_s [0:TRIG_BITS];

	logic [31:0]          p_turn;
	logic [31:0]          u_turn;
	logic signed [ZW-1:0] z_init;

	// Quadrant reduction leaves a residual in [-1/8, 1/8) turn.
	always_comb begin
		p_turn = 32'(phase) << RS;
		u_turn = p_turn + 32'h2000_0000;
		z_init = $signed({2'b00, u_turn[29:0]}) - 32'sh2000_0000;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s[0]    <= CORDIC_K;
			y_s[0]    <= '0;
			z_s[0]    <= z_init;
			quad_s[0] <= u_turn[31:30];
		end
	end

	for (genvar i = 0; i < TRIG_BITS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = $signed(atan_turn(i));
		logic signed [XW-1:0] dx, dy;
		always_comb begin
			dx = y_s[i] >>> i;
			dy = x_s[i] >>> i;
		end
		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ANG;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ANG;
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	logic signed [XW-1:0]    xr_w, yr_w;
	logic signed [TRIG_BITS:0] xr, yr;

	always_comb begin
		xr_w = (x_s[TRIG_BITS] + RND) >>> RS;
		yr_w = (y_s[TRIG_BITS] + RND) >>> RS;
		xr   = xr_w[TRIG_BITS:0];
		yr   = yr_w[TRIG_BITS:0];
	end

	always_ff @(posedge clk) begin
		if (adv[TRIG_BITS+1]) begin
			case (quad_s[TRIG_BITS])
				2'd0: begin
					cos_val <= xr;
					sin_val <= yr;
				end
				2'd1: begin
					cos_val <= -yr;
					sin_val <= xr;
				end
				2'd2: begin
					cos_val <= -xr;
					sin_val <= -yr;
				end
				default: begin
					cos_val <= yr;
					sin_val <= -xr;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/uv_sphere_grid_point.sv =====
// ----------------------------------------------------------------------------
// UV sphere grid point
// Streams grid points of a UV sphere into vertex, texture and face records.
// ----------------------------------------------------------------------------
// Every grid point (row, col) gives exactly one result record, in order, with
// one transaction accepted per clock cycle while the output takes results. The
// pipeline holds the entry stage, then the four restoring dividers, which
// resolve one quotient bit per stage for a quotient of QW bits, QW being the
// larger of TRIG_BITS + 1 and 17, then the two CORDIC units with one rotation
// per stage, two multiply stages and the rounding logic that feeds the output
// register. Bubbles collapse: a stage takes new data whenever it is empty or
// the stage ahead moves, so input keeps flowing while a result waits at the
// output. Configuration writes are always taken; ring and segment act on the
// next accepted point, radius on each point entering the first multiply;
// they are meant to be issued only while no point is in flight.
`timescale 1ns / 1ps
`include "uv_sphere_grid_point_defines.svh"
module uv_sphere_grid_point #(
	parameter int MAX_GRID  = usg_pkg::DEF_MAX_GRID,
	parameter int TRIG_BITS = usg_pkg::DEF_TRIG_BITS
) (
	input logic           clk,
	input logic           arst_n,
	usg_cfg_if.sink       cfg,
	usg_in_if.sink        pt_in,
	usg_out_if.source     vtx_out
);
	import usg_pkg::*;

	// Quotient width covers phases up to one full turn and texture up to 1.0.
	localparam int QW   = (TRIG_BITS + 1 > 17) ? TRIG_BITS + 1 : 17;
	localparam int NW   = DIV_DW + QW;
	localparam int NDIV = QW;
	localparam int CST  = TRIG_BITS + 2;
	localparam int C0   = NDIV + 1;
	localparam int M1   = C0 + CST;
	localparam int M2   = M1 + 1;
	localparam int M3   = M2 + 1;
	localparam int NST  = M3 + 1;
	localparam int TW   = TRIG_BITS + 1;
	localparam int ZW   = TRIG_BITS + 18;
	localparam int PW   = 2 * TRIG_BITS + 19;

	localparam logic signed [PW-1:0] XY_RND = PW'(1) <<< (2 * TRIG_BITS - 5);
	localparam logic signed [ZW-1:0] Z_RND  = ZW'(1) <<< (TRIG_BITS - 3);
	localparam logic signed [PW-1:0] XY_MAX = PW'(POS_LIMIT);
	localparam logic signed [ZW-1:0] Z_MAX  = ZW'(POS_LIMIT);
	localparam logic signed [POS_W-1:0] SAT_HI = POS_W'(POS_LIMIT);

	// Configuration registers. The port never back-pressures.
	logic [CFG_DATA_W-1:0] radius_q;
	logic [GRID_W-1:0]     ring_q;
	logic [GRID_W-1:0]     segment_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			ring_q    <= RING_RST;
			segment_q <= SEGMENT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RADIUS:  radius_q  <= cfg.data;
				REG_RING:    ring_q    <= cfg.data[GRID_W-1:0];
				REG_SEGMENT: segment_q <= cfg.data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	// Grid sizes below two act as two and sizes above MAX_GRID as MAX_GRID.
	function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] v);
		logic [GRID_W-1:0] r;
		if (int'(v) < 2) r = GRID_W'(2);
		else if (int'(v) > MAX_GRID) r = GRID_W'(MAX_GRID);
		else r = v;
		return r;
	endfunction

	// Doubled divisor of each divider lane: theta, phi, texture s, texture t.
	function automatic logic [DIV_DW-1:0] lane_div(input int lane, input side_t sd);
		logic [DIV_DW-1:0] d;
		case (lane)
			0:       d = {sd.rm1, 2'b00};
			1:       d = {1'b0, sd.sm1, 1'b0};
			2:       d = {1'b0, sd.sm1, 1'b0};
			default: d = {1'b0, sd.rm1, 1'b0};
		endcase
		return d;
	endfunction

	// Stage handshake: a stage advances when it is empty or the next one does.
	logic [NST-1:0] valid_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !valid_q[NST-1] || vtx_out.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign pt_in.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) valid_q[0] <= pt_in.valid;
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	// Entry stage: clamp the grid, classify the point, set up the dividends.
	// Each lane divides 2*num + den by 2*den, which rounds half up.
	logic [GRID_W-1:0] rr, ss, rm1, sm1;
	logic [NW-1:0]     n2 [0:3];
	side_t             side_in;

	always_comb begin
		rr  = clamp_grid(ring_q);
		ss  = clamp_grid(segment_q);
		rm1 = rr - GRID_W'(1);
		sm1 = ss - GRID_W'(1);
		side_in.in_range = (GRID_W'(pt_in.row_index) < rr) && (GRID_W'(pt_in.col_index) < ss);
		side_in.faces    = side_in.in_range && (pt_in.row_index != '0)
			&& (GRID_W'(pt_in.col_index) != sm1);
		side_in.ra    = RA_W'(pt_in.row_index) * RA_W'(ss) + RA_W'(pt_in.col_index);
		side_in.rm1   = rm1;
		side_in.sm1   = sm1;
		side_in.tex_s = '0;
		side_in.tex_t = '0;
		n2[0] = (NW'(pt_in.row_index) << (TRIG_BITS + 1)) + NW'({rm1, 1'b0});
		n2[1] = (NW'(pt_in.col_index) << (TRIG_BITS + 1)) + NW'(sm1);
		n2[2] = (NW'(pt_in.col_index) << (TEX_SHIFT + 1)) + NW'(sm1);
		n2[3] = (NW'(pt_in.row_index) << (TEX_SHIFT + 1)) + NW'(rm1);
	end

	side_t             side_s [0:NST-1];
	logic [DIV_DW-1:0] rem_s  [0:NDIV][0:3];
	logic [QW-1:0]     nq_s   [0:NDIV][0:3];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s[0] <= side_in;
			for (int l = 0; l < 4; l++) begin
				rem_s[0][l] <= n2[l][NW-1:QW];
				nq_s[0][l]  <= n2[l][QW-1:0];
			end
		end
	end

	// Restoring division, one quotient bit per stage; the dividend's low bits
	// shift out as the quotient bits shift in.
	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [DIV_DW:0]   trial;
			logic [DIV_DW-1:0] dv;
			logic [DIV_DW-1:0] rem_nx;
			logic              qbit;
			always_comb begin
				dv    = lane_div(l, side_s[k-1]);
				trial = {rem_s[k-1][l], nq_s[k-1][l][QW-1]};
				qbit  = trial >= {1'b0, dv};
				rem_nx = qbit ? DIV_DW'(trial - {1'b0, dv}) : trial[DIV_DW-1:0];
			end
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_s[k][l] <= rem_nx;
					nq_s[k][l]  <= {nq_s[k-1][l][QW-2:0], qbit};
				end
			end
		end
	end

	// Sideband travels with the item; texture joins it after the dividers.
	side_t side_tex;

	always_comb begin
		side_tex       = side_s[C0-1];
		side_tex.tex_s = nq_s[NDIV][2][TEX_W-1:0];
		side_tex.tex_t = TEX_ONE - nq_s[NDIV][3][TEX_W-1:0];
	end

	for (genvar k = 1; k < NST; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				side_s[k] <= (k == C0) ? side_tex : side_s[k-1];
			end
		end
	end

	// Sine and cosine of theta and phi; phi wraps modulo one turn.
	logic signed [TW-1:0] cos_t, sin_t, cos_p, sin_p;

	usg_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic_theta (
		.clk     (clk),
		.adv     (adv[C0+CST-1:C0]),
		.phase   (nq_s[NDIV][0][TRIG_BITS-1:0]),
		.cos_val (cos_t),
		.sin_val (sin_t)
	);

	usg_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic_phi (
		.clk     (clk),
		.adv     (adv[C0+CST-1:C0]),
		.phase   (nq_s[NDIV][1][TRIG_BITS-1:0]),
		.cos_val (cos_p),
		.sin_val (sin_p)
	);

	// First multiply: scale sin(theta) and cos(theta) by the radius.
	logic signed [ZW-1:0] st_r_s, ct_r_s;
	logic signed [TW-1:0] cp_s, sp_s;
	logic signed [ZW-1:0] rad_ext;

	assign rad_ext = ZW'($signed({1'b0, radius_q}));

	always_ff @(posedge clk) begin
		if (adv[M1]) begin
			st_r_s <= ZW'(sin_t) * rad_ext;
			ct_r_s <= ZW'(cos_t) * rad_ext;
			cp_s   <= cos_p;
			sp_s   <= sin_p;
		end
	end

	// Second multiply: apply the azimuth terms.
	logic signed [PW-1:0] px_s, py_s;
	logic signed [ZW-1:0] pz_s;

	always_ff @(posedge clk) begin
		if (adv[M2]) begin
			px_s <= PW'(st_r_s) * PW'(cp_s);
			py_s <= PW'(st_r_s) * PW'(sp_s);
			pz_s <= ct_r_s;
		end
	end

	// Round half up back to Q8.8, saturate, and zero what the point lacks.
	logic signed [PW-1:0]    rx, ry;
	logic signed [ZW-1:0]    rz;
	logic signed [POS_W-1:0] sx, sy, sz;
	logic [RA_W-1:0]         c_full;
	side_t                   so;

	always_comb begin
		so = side_s[M2];
		rx = (px_s + XY_RND) >>> (2 * TRIG_BITS - 4);
		ry = (py_s + XY_RND) >>> (2 * TRIG_BITS - 4);
		rz = (pz_s + Z_RND) >>> (TRIG_BITS - 2);
		if (rx > XY_MAX) sx = SAT_HI;
		else if (rx < -XY_MAX) sx = -SAT_HI;
		else sx = rx[POS_W-1:0];
		if (ry > XY_MAX) sy = SAT_HI;
		else if (ry < -XY_MAX) sy = -SAT_HI;
		else sy = ry[POS_W-1:0];
		if (rz > Z_MAX) sz = SAT_HI;
		else if (rz < -Z_MAX) sz = -SAT_HI;
		else sz = rz[POS_W-1:0];
		c_full = so.ra - RA_W'(so.sm1) - RA_W'(1);
	end

	always_ff @(posedge clk) begin
		if (adv[M3]) begin
			vtx_out.pos_x     <= so.in_range ? sx : '0;
			vtx_out.pos_y     <= so.in_range ? sy : '0;
			vtx_out.pos_z     <= so.in_range ? sz : '0;
			vtx_out.tex_s     <= so.in_range ? so.tex_s : '0;
			vtx_out.tex_t     <= so.in_range ? so.tex_t : '0;
			vtx_out.in_range  <= so.in_range;
			vtx_out.has_faces <= so.faces;
			vtx_out.corner_a  <= so.faces ? so.ra[CORNER_W-1:0] : '0;
			vtx_out.corner_b  <= so.faces ? CORNER_W'(c_full + RA_W'(1)) : '0;
			vtx_out.corner_c  <= so.faces ? c_full[CORNER_W-1:0] : '0;
			vtx_out.corner_d  <= so.faces ? CORNER_W'(so.ra + RA_W'(1)) : '0;
		end
	end

	assign vtx_out.valid = valid_q[NST-1];

	`USG_ASSERT(a_faces_in_range, !vtx_out.valid || !vtx_out.has_faces || vtx_out.in_range, "faces on a point outside the grid")
	`USG_ASSERT(a_out_zero, !vtx_out.valid || vtx_out.in_range || (vtx_out.pos_x == '0 && vtx_out.pos_z == '0 && vtx_out.tex_t == '0), "outside point has nonzero fields")
	`USG_ASSERT(a_corner_da, !vtx_out.valid || !vtx_out.has_faces || vtx_out.corner_d == CORNER_W'(vtx_out.corner_a + 20'd1), "corner d is not corner a plus one")
	`USG_ASSERT(a_corner_bc, !vtx_out.valid || !vtx_out.has_faces || vtx_out.corner_b == CORNER_W'(vtx_out.corner_c + 20'd1), "corner b is not corner c plus one")
	`USG_ASSERT_NEXT(a_stall_hold, valid_q[0] && !adv[1], valid_q[0], "entry stage lost an item while stalled")

endmodule
